// ===== design/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU package
// Opcodes, error codes, field widths and the control types shared by the
// stack cells, the multiply/divide unit and the top level.
// ----------------------------------------------------------------------------
package sma_pkg;

   // Widths of the beat fields on the request and response channels.
   localparam int OPCODE_WIDTH = 5;
   localparam int VALUE_WIDTH  = 64;
   localparam int DEPTH_WIDTH  = 6;
   localparam int ERROR_WIDTH  = 2;

   // Primitive words. Codes above OP_LITERAL are no-ops.
   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_DROP    = 5'd0,
      OP_DUP     = 5'd1,
      OP_ADD     = 5'd2,
      OP_SUB     = 5'd3,
      OP_MUL     = 5'd4,
      OP_DIV     = 5'd5,
      OP_MOD     = 5'd6,
      OP_SWAP    = 5'd7,
      OP_ROT     = 5'd8,
      OP_ROTBACK = 5'd9,
      OP_OVER    = 5'd10,
      OP_TRUE    = 5'd11,
      OP_FALSE   = 5'd12,
      OP_XOR     = 5'd13,
      OP_OR      = 5'd14,
      OP_AND     = 5'd15,
      OP_NOT     = 5'd16,
      OP_EQ      = 5'd17,
      OP_LT      = 5'd18,
      OP_WITHIN  = 5'd19,
      OP_LITERAL = 5'd20
   } sma_op_type;

   typedef enum logic [ERROR_WIDTH-1:0] {
      ERR_OK        = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_DIVIDE    = 2'd3
   } sma_err_type;

   // How the row of stack cells moves in one step.
   typedef enum logic [1:0] {
      SH_HOLD = 2'd0,
      SH_PUSH = 2'd1,
      SH_POP1 = 2'd2,
      SH_POP2 = 2'd3
   } sma_shift_type;

   // Per-cell control: step enables the update, write overrides the shift.
   typedef struct packed {
      logic          step;
      sma_shift_type shift;
      logic          write;
   } sma_cell_ctl_type;

   // Operation of the multi-cycle arithmetic unit.
   typedef enum logic [1:0] {
      KIND_MUL = 2'd0,
      KIND_DIV = 2'd1,
      KIND_MOD = 2'd2
   } sma_kind_type;

   typedef struct packed {
      logic         start;
      sma_kind_type kind;
   } sma_md_cmd_type;

   // Number of cells a word consumes.
   function automatic logic [1:0] op_pops(input sma_op_type op);
      logic [1:0] n;
      case (op) inside
         OP_DROP, OP_DUP, OP_NOT:                      n = 2'd1;
         OP_ROT, OP_ROTBACK, OP_WITHIN:                n = 2'd3;
         OP_TRUE, OP_FALSE, OP_LITERAL:                n = 2'd0;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
         OP_SWAP, OP_OVER, OP_XOR, OP_OR, OP_AND,
         OP_EQ, OP_LT:                                 n = 2'd2;
         default:                                      n = 2'd0;
      endcase
      return n;
   endfunction

   // Number of cells a word leaves in place of those it consumed.
   function automatic logic [1:0] op_pushes(input sma_op_type op);
      logic [1:0] n;
      case (op) inside
         OP_DROP:                                      n = 2'd0;
         OP_DUP, OP_SWAP:                              n = 2'd2;
         OP_ROT, OP_ROTBACK, OP_OVER:                  n = 2'd3;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
         OP_TRUE, OP_FALSE, OP_XOR, OP_OR, OP_AND,
         OP_NOT, OP_EQ, OP_LT, OP_WITHIN, OP_LITERAL:  n = 2'd1;
         default:                                      n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== design/sma_req_if.sv =====
// ----------------------------------------------------------------------------
// Stack machine request channel
// Valid/ready channel that carries one primitive word per beat.
// ----------------------------------------------------------------------------
interface sma_req_if;
   import sma_pkg::*;

   logic                           valid;
   logic                           ready;
   logic [OPCODE_WIDTH-1:0]        operation;
   logic signed [VALUE_WIDTH-1:0]  literal_value;

   modport source (output valid, output operation, output literal_value, input ready);
   modport sink   (input valid, input operation, input literal_value, output ready);

endinterface

// ===== design/sma_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Stack machine response channel
// Valid/ready channel that carries the stack status after each word.
// ----------------------------------------------------------------------------
interface sma_rsp_if;
   import sma_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [VALUE_WIDTH-1:0]  top_value;
   logic [DEPTH_WIDTH-1:0]         stack_depth;
   logic [ERROR_WIDTH-1:0]         error_code;

   modport source (output valid, output top_value, output stack_depth, output error_code,
                   input ready);
   modport sink   (input valid, input top_value, input stack_depth, input error_code,
                   output ready);

endinterface

// ===== design/stack_machine_alu.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU
// Forth-style data stack held in a row of shifting cells, with an ALU on the
// three top cells and a multi-cycle multiply/divide unit.
// Response: the response beat is registered at the edge that takes the word and
//   shows in the following cycle; mul, and div and mod that do not fault, answer
//   only once the multiply/divide unit finishes.
// Throughput: one word per cycle while the response channel is not stalled; those
//   arithmetic words hold off new words until their response beat shows.
// Reset: synchronous; empties the stack, cell contents are left as they are.
// ----------------------------------------------------------------------------
module stack_machine_alu #(
   parameter int STACK_DEPTH = 32,
   parameter int CELL_WIDTH  = 64
) (
   input logic        clock,
   input logic        reset,
   sma_req_if.sink    req_if,
   sma_rsp_if.source  rsp_if
);
   import sma_pkg::*;

   localparam int PW = $clog2(STACK_DEPTH + 1);
   localparam logic [CELL_WIDTH-1:0] CELL_MIN = {1'b1, {(CELL_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      S_READY = 2'b01,
      S_ARITH = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [PW-1:0] depth_ff, depth_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic signed [VALUE_WIDTH-1:0] top_value_ff, top_value_in;
   logic [DEPTH_WIDTH-1:0]        stack_depth_ff;
   logic [ERROR_WIDTH-1:0]        error_code_ff;
   sma_err_type                   err_in;

   logic [CELL_WIDTH-1:0] cell_value [STACK_DEPTH];
   logic [CELL_WIDTH-1:0] top0, top1, top2;

   sma_op_type            op;
   logic [1:0]            n_pop, n_push;
   logic [PW:0]           depth_sum;
   logic                  accept, finish, rsp_load;

   // Decoded word.
   sma_err_type           dec_err;
   logic                  dec_commit;
   logic                  dec_start;
   sma_kind_type          dec_kind;
   sma_shift_type         dec_shift;
   logic [2:0]            dec_wen;
   logic [CELL_WIDTH-1:0] dec_wdata [3];

   // Merged control for the cell row.
   logic                  step;
   sma_shift_type         shift;
   logic [2:0]            wen;
   logic [CELL_WIDTH-1:0] wdata [3];
   logic [CELL_WIDTH-1:0] cell0_next;
   logic signed [CELL_WIDTH-1:0] cell0_signed;

   sma_md_cmd_type        md_cmd;
   logic                  md_done;
   logic [CELL_WIDTH-1:0] md_result;

   assign top0 = cell_value[0];
   assign top1 = cell_value[1];
   assign top2 = cell_value[2];

   assign op        = sma_op_type'(req_if.operation);
   assign n_pop     = op_pops(op);
   assign n_push    = op_pushes(op);
   assign depth_sum = (PW+1)'(depth_ff) + (PW+1)'(n_push) - (PW+1)'(n_pop);

   assign req_if.ready = (state_ff == S_READY) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign finish       = (state_ff == S_ARITH) && md_done;

   // Word decode: depth checks first, then the new values of the top cells.
   always_comb begin
      dec_err    = ERR_OK;
      dec_commit = 1'b0;
      dec_start  = 1'b0;
      dec_kind   = KIND_MUL;
      dec_shift  = SH_HOLD;
      dec_wen    = 3'b000;
      dec_wdata[0] = '0;
      dec_wdata[1] = '0;
      dec_wdata[2] = '0;
      if (depth_ff < PW'(n_pop)) begin
         dec_err = ERR_UNDERFLOW;
      end else if (depth_sum > (PW+1)'(STACK_DEPTH)) begin
         dec_err = ERR_OVERFLOW;
      end else begin
         dec_commit = 1'b1;
         unique case (op) inside
            OP_DROP: begin
               dec_shift = SH_POP1;
            end
            OP_DUP: begin
               dec_shift    = SH_PUSH;
               dec_wen      = 3'b001;
               dec_wdata[0] = top0;
            end
            OP_ADD: begin
               dec_shift    = SH_POP1;
               dec_wen      = 3'b001;
               dec_wdata[0] = top1 + top0;
            end
            OP_SUB: begin
               dec_shift    = SH_POP1;
               dec_wen      = 3'b001;
               dec_wdata[0] = top1 - top0;
            end
            OP_MUL: begin
               dec_commit = 1'b0;
               dec_start  = 1'b1;
               dec_kind   = KIND_MUL;
            end
            OP_DIV, OP_MOD: begin
               dec_commit = 1'b0;
               if (top0 == '0 || (top1 == CELL_MIN && top0 == '1)) begin
                  dec_err = ERR_DIVIDE;
               end else begin
                  dec_start = 1'b1;
                  dec_kind  = (op == OP_DIV) ? KIND_DIV : KIND_MOD;
               end
            end
            OP_SWAP: begin
               dec_wen      = 3'b011;
               dec_wdata[0] = top1;
               dec_wdata[1] = top0;
            end
            OP_ROT: begin
               dec_wen      = 3'b111;
               dec_wdata[0] = top2;
               dec_wdata[1] = top0;
               dec_wdata[2] = top1;
            end
            OP_ROTBACK: begin
               dec_wen      = 3'b111;
               dec_wdata[0] = top1;
               dec_wdata[1] = top2;
               dec_wdata[2] = top0;
            end
            OP_OVER: begin
               dec_shift    = SH_PUSH;
               dec_wen      = 3'b001;
               dec_wdata[0] = top1;
            end
            OP_TRUE: begin
               dec_shift    = SH_PUSH;
               dec_wen      = 3'b001;
               dec_wdata[0] = '1;
            end
            OP_FALSE: begin
               dec_shift    = SH_PUSH;
               dec_wen      = 3'b001;
               dec_wdata[0] = '0;
            end
            OP_LITERAL: begin
               dec_shift    = SH_PUSH;
               dec_wen      = 3'b001;
               dec_wdata[0] = req_if.literal_value[CELL_WIDTH-1:0];
            end
            OP_XOR: begin
               dec_shift    = SH_POP1;
               dec_wen      = 3'b001;
               dec_wdata[0] = top1 ^ top0;
            end
            OP_OR: begin
               dec_shift    = SH_POP1;
               dec_wen      = 3'b001;
               dec_wdata[0] = top1 | top0;
            end
            OP_AND: begin
               dec_shift    = SH_POP1;
               dec_wen      = 3'b001;
               dec_wdata[0] = top1 & top0;
            end
            OP_NOT: begin
               dec_wen      = 3'b001;
               dec_wdata[0] = ~top0;
            end
            OP_EQ: begin
               dec_shift    = SH_POP1;
               dec_wen      = 3'b001;
               dec_wdata[0] = {CELL_WIDTH{top1 == top0}};
            end
            OP_LT: begin
               dec_shift    = SH_POP1;
               dec_wen      = 3'b001;
               dec_wdata[0] = {CELL_WIDTH{$signed(top1) < $signed(top0)}};
            end
            OP_WITHIN: begin
               dec_shift    = SH_POP2;
               dec_wen      = 3'b001;
               dec_wdata[0] = {CELL_WIDTH{!($signed(top2) < $signed(top1)) &&
                                          ($signed(top2) < $signed(top0))}};
            end
            default: begin
               // Unassigned opcodes leave the stack alone.
            end
         endcase
      end
   end

   // The arithmetic unit's result replaces its two operands when it finishes.
   always_comb begin
      step     = (accept && dec_commit) || finish;
      shift    = finish ? SH_POP1 : dec_shift;
      wen      = finish ? 3'b001 : dec_wen;
      wdata[0] = finish ? md_result : dec_wdata[0];
      wdata[1] = dec_wdata[1];
      wdata[2] = dec_wdata[2];
   end

   // Value of the top cell after this cycle, for the response beat.
   always_comb begin
      if (!step) begin
         cell0_next = top0;
      end else if (wen[0]) begin
         cell0_next = wdata[0];
      end else begin
         case (shift)
            SH_POP1: cell0_next = top1;
            SH_POP2: cell0_next = top2;
            default: cell0_next = top0;
         endcase
      end
   end

   assign cell0_signed = cell0_next;

   // Stack pointer, response register and state.
   always_comb begin
      depth_in = depth_ff;
      if (finish) begin
         depth_in = depth_ff - PW'(1);
      end else if (accept && dec_commit) begin
         depth_in = depth_sum[PW-1:0];
      end
      rsp_load     = (accept && !dec_start) || finish;
      err_in       = finish ? ERR_OK : dec_err;
      top_value_in = (depth_in == '0) ? '0 : VALUE_WIDTH'(cell0_signed);
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      state_in = state_ff;
      unique case (state_ff)
         S_READY: if (accept && dec_start) state_in = S_ARITH;
         S_ARITH: if (md_done) state_in = S_READY;
         default: state_in = S_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_READY;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         top_value_ff   <= top_value_in;
         stack_depth_ff <= DEPTH_WIDTH'(depth_in);
         error_code_ff  <= err_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.top_value   = top_value_ff;
   assign rsp_if.stack_depth = stack_depth_ff;
   assign rsp_if.error_code  = error_code_ff;

   // Row of stack cells; cell 0 is the top of the stack.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stack
      sma_cell_ctl_type      ctl;
      logic [CELL_WIDTH-1:0] above, below1, below2, wr_data;

      if (i < 3) begin : g_alu_port
         assign ctl.write = wen[i];
         assign wr_data   = wdata[i];
      end else begin : g_no_port
         assign ctl.write = 1'b0;
         assign wr_data   = '0;
      end

      if (i == 0) begin : g_head
         assign above = '0;
      end else begin : g_body
         assign above = cell_value[i-1];
      end

      if (i + 1 < STACK_DEPTH) begin : g_next1
         assign below1 = cell_value[i+1];
      end else begin : g_end1
         assign below1 = '0;
      end

      if (i + 2 < STACK_DEPTH) begin : g_next2
         assign below2 = cell_value[i+2];
      end else begin : g_end2
         assign below2 = '0;
      end

      assign ctl.step  = step;
      assign ctl.shift = shift;

      sma_cell #(
         .CELL_WIDTH (CELL_WIDTH)
      ) u_stack_entry (
         .clock       (clock),
         .ctl         (ctl),
         .from_above  (above),
         .from_below1 (below1),
         .from_below2 (below2),
         .write_data  (wr_data),
         .value       (cell_value[i])
      );
   end

   // Multiply/divide unit works on the second and top cells.
   assign md_cmd.start = accept && dec_start;
   assign md_cmd.kind  = dec_kind;

   sma_muldiv #(
      .CELL_WIDTH (CELL_WIDTH)
   ) u_muldiv (
      .clock     (clock),
      .reset     (reset),
      .cmd       (md_cmd),
      .operand_a (top1),
      .operand_b (top0),
      .done      (md_done),
      .result    (md_result)
   );

endmodule

// ===== design/sma_cell.sv =====
// ----------------------------------------------------------------------------
// Stack cell
// One entry of the shifting stack. It takes its neighbor's value on a push
// or pop, or a value written from the ALU when the top cells are rewritten.
// ----------------------------------------------------------------------------
module sma_cell #(
   parameter int CELL_WIDTH = 64
) (
   input  logic                     clock,
   input  sma_pkg::sma_cell_ctl_type ctl,
   input  logic [CELL_WIDTH-1:0]    from_above,
   input  logic [CELL_WIDTH-1:0]    from_below1,
   input  logic [CELL_WIDTH-1:0]    from_below2,
   input  logic [CELL_WIDTH-1:0]    write_data,
   output logic [CELL_WIDTH-1:0]    value
);
   import sma_pkg::*;

   logic [CELL_WIDTH-1:0] value_ff;
   logic [CELL_WIDTH-1:0] value_in;

   // Select the neighbor for the shift, then let a direct write win.
   always_comb begin
      unique case (ctl.shift)
         SH_HOLD: value_in = value_ff;
         SH_PUSH: value_in = from_above;
         SH_POP1: value_in = from_below1;
         SH_POP2: value_in = from_below2;
         default: value_in = value_ff;
      endcase
      if (ctl.write) begin
         value_in = write_data;
      end
   end

   // Cell contents carry no reset; entries above the depth are never shown.
   always_ff @(posedge clock) begin
      if (ctl.step) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== design/sma_muldiv.sv =====
// ----------------------------------------------------------------------------
// Multiply/divide unit
// Multiplies sixteen multiplier bits per cycle, and divides with a restoring
// divider that retires one quotient bit per cycle on operand magnitudes.
// ----------------------------------------------------------------------------
module sma_muldiv #(
   parameter int CELL_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sma_pkg::sma_md_cmd_type cmd,
   input  logic [CELL_WIDTH-1:0]   operand_a,
   input  logic [CELL_WIDTH-1:0]   operand_b,
   output logic                    done,
   output logic [CELL_WIDTH-1:0]   result
);
   import sma_pkg::*;

   localparam int DIGIT     = 16;
   localparam int MUL_STEPS = (CELL_WIDTH + DIGIT - 1) / DIGIT;
   localparam int CNT_W     = $clog2(CELL_WIDTH);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   sma_kind_type          kind_ff, kind_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CELL_WIDTH-1:0] acc_ff, acc_in;
   logic [CELL_WIDTH-1:0] x_ff, x_in;
   logic [CELL_WIDTH-1:0] y_ff, y_in;
   logic                  neg_q_ff, neg_q_in;
   logic                  neg_r_ff, neg_r_in;

   logic [CELL_WIDTH+DIGIT-1:0] partial;
   logic [CELL_WIDTH:0]         shifted;
   logic [CELL_WIDTH:0]         diff;
   logic [CNT_W-1:0]            last_count;

   assign partial    = x_ff * y_ff[DIGIT-1:0];
   assign shifted    = {acc_ff, y_ff[CELL_WIDTH-1]};
   assign diff       = shifted - {1'b0, x_ff};
   assign last_count = (kind_ff == KIND_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(CELL_WIDTH - 1);

   // Load on start, then one multiply digit or one quotient bit per cycle.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      kind_in  = kind_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         kind_in  = cmd.kind;
         count_in = '0;
         acc_in   = '0;
         neg_q_in = operand_a[CELL_WIDTH-1] ^ operand_b[CELL_WIDTH-1];
         neg_r_in = operand_a[CELL_WIDTH-1];
         if (cmd.kind == KIND_MUL) begin
            x_in = operand_a;
            y_in = operand_b;
         end else begin
            x_in = operand_b[CELL_WIDTH-1] ? ('0 - operand_b) : operand_b;
            y_in = operand_a[CELL_WIDTH-1] ? ('0 - operand_a) : operand_a;
         end
      end else if (busy_ff) begin
         if (kind_ff == KIND_MUL) begin
            acc_in = acc_ff + partial[CELL_WIDTH-1:0];
            x_in   = x_ff << DIGIT;
            y_in   = y_ff >> DIGIT;
         end else if (!diff[CELL_WIDTH]) begin
            acc_in = diff[CELL_WIDTH-1:0];
            y_in   = {y_ff[CELL_WIDTH-2:0], 1'b1};
         end else begin
            acc_in = shifted[CELL_WIDTH-1:0];
            y_in   = {y_ff[CELL_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + CNT_W'(1);
         if (count_ff == last_count) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      count_ff <= count_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // Restore the signs: the quotient truncates toward zero and the
   // remainder follows the dividend.
   always_comb begin
      unique case (kind_ff)
         KIND_MUL: result = acc_ff;
         KIND_DIV: result = neg_q_ff ? ('0 - y_ff) : y_ff;
         KIND_MOD: result = neg_r_ff ? ('0 - acc_ff) : acc_ff;
         default:  result = acc_ff;
      endcase
   end

   assign done = done_ff;

endmodule

// ===== design/sma_checker.sv =====
// ----------------------------------------------------------------------------
// Stack machine ALU checker
// Port-level assertions on the response stream, bound to the top level.
// ----------------------------------------------------------------------------
module sma_checker #(
   parameter int STACK_DEPTH = 32
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [sma_pkg::VALUE_WIDTH-1:0]   rsp_top_value,
   input logic [sma_pkg::DEPTH_WIDTH-1:0]   rsp_stack_depth,
   input logic [sma_pkg::ERROR_WIDTH-1:0]   rsp_error_code
);
   import sma_pkg::*;

   logic [1:0]             pending_ff, pending_in;
   logic [DEPTH_WIDTH-1:0] last_depth_ff, last_depth_in;
   logic                   req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Words taken but not yet answered, and the depth of the last answer.
   always_comb begin
      pending_in    = pending_ff + 2'(req_beat) - 2'(rsp_beat);
      last_depth_in = rsp_beat ? rsp_stack_depth : last_depth_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         last_depth_ff <= '0;
      end else begin
         pending_ff    <= pending_in;
         last_depth_ff <= last_depth_in;
      end
   end

   // Every response beat answers a word that was taken earlier.
   a_rsp_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response beat without an outstanding word");

   // A faulting word leaves the stack depth where it was.
   a_fault_keeps_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_UNDERFLOW || rsp_error_code == ERR_OVERFLOW ||
                    rsp_error_code == ERR_DIVIDE)
      |-> rsp_stack_depth == last_depth_ff)
      else $error("stack depth changed on a faulting word");

   // An empty stack shows a zero top value; checked only while STACK_DEPTH is below 64.
   a_empty_top_zero: assert property (@(posedge clock) disable iff (reset)
      (STACK_DEPTH < 64) && rsp_valid && rsp_stack_depth == '0 |-> rsp_top_value == '0)
      else $error("nonzero top value on an empty stack");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value) &&
                                  $stable(rsp_stack_depth) && $stable(rsp_error_code))
      else $error("stalled response beat changed");

endmodule

bind stack_machine_alu sma_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_sma_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_top_value   (rsp_if.top_value),
   .rsp_stack_depth (rsp_if.stack_depth),
   .rsp_error_code  (rsp_if.error_code)
);
